// ----- design/bts_pkg.sv -----
// Shared types and constants for the backoff timeout sequencer.
`timescale 1ns / 1ps

package bts_pkg;

  localparam int DUR_W       = 32;
  localparam int MULT_W      = 16;
  localparam int FRAC_W      = 8;
  localparam int TABLE_DEPTH = 16;
  localparam int IDX_W       = 4;
  localparam int USED_W      = 5;
  localparam int COUNT_W     = 16;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 32;
  localparam int PROD_W      = DUR_W + MULT_W;

  // Operation codes carried by an input word.
  typedef enum logic [1:0] {
    OP_RESTART      = 2'd0,
    OP_NEXT         = 2'd1,
    OP_LOAD_ATTEMPT = 2'd2,
    OP_LOAD_RETRY   = 2'd3
  } op_t;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ATTEMPT_MULT  = 3'd0,
    CFG_RETRY_MULT    = 3'd1,
    CFG_ATTEMPT_LIMIT = 3'd2,
    CFG_RETRY_LIMIT   = 3'd3,
    CFG_ATTEMPT_USED  = 3'd4,
    CFG_RETRY_USED    = 3'd5
  } cfg_idx_t;

  // Per-channel control for one committed word.
  typedef struct packed {
    logic               restart;
    logic               advance;
    logic               load;
    logic [IDX_W-1:0]   load_index;
    logic [DUR_W-1:0]   load_value;
    logic [COUNT_W-1:0] count_next;
    logic [MULT_W-1:0]  mult;
    logic [DUR_W-1:0]   limit;
    logic [USED_W-1:0]  used;
  } chan_ctrl_t;

endpackage

// ----- design/bts_if.sv -----
// Valid/ready channel interfaces for input and result words.
`timescale 1ns / 1ps

interface bts_in_if;
  import bts_pkg::*;

  logic             valid;
  logic             ready;
  logic [1:0]       op;
  logic [IDX_W-1:0] entry_index;
  logic [DUR_W-1:0] duration_value;

  modport source (output valid, output op, output entry_index, output duration_value,
                  input ready);
  modport sink (input valid, input op, input entry_index, input duration_value,
                output ready);
endinterface

interface bts_out_if;
  import bts_pkg::*;

  logic               valid;
  logic               ready;
  logic [DUR_W-1:0]   attempt_timeout;
  logic [DUR_W-1:0]   retry_delay;
  logic [COUNT_W-1:0] attempt_count;

  modport source (output valid, output attempt_timeout, output retry_delay,
                  output attempt_count, input ready);
  modport sink (input valid, input attempt_timeout, input retry_delay,
                input attempt_count, output ready);
endinterface

// ----- design/bts_channel.sv -----
// One backoff channel: duration table, growth multiply, limit clamp and current value.
`timescale 1ns / 1ps

module bts_channel (
  input  logic                      clk,
  input  logic                      rst,
  input  bts_pkg::chan_ctrl_t       ctrl,
  output logic [bts_pkg::DUR_W-1:0] value
);
  import bts_pkg::*;

  logic [DUR_W-1:0]         tbl [TABLE_DEPTH];
  logic [USED_W-1:0]        used_n;
  logic [IDX_W-1:0]         rd_addr;
  logic                     use_table;
  logic [PROD_W-1:0]        product;
  logic [PROD_W-FRAC_W-1:0] shifted;
  logic [DUR_W-1:0]         grown;
  logic [DUR_W-1:0]         picked;
  logic [DUR_W-1:0]         clamped;
  logic                     update;

  // Table writes from load words.
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      tbl[ctrl.load_index] <= ctrl.load_value;
    end
  end

  // Entries in use, limited to the table depth.
  assign used_n = (ctrl.used > USED_W'(TABLE_DEPTH)) ? USED_W'(TABLE_DEPTH) : ctrl.used;

  // A restart reads the first entry; a next word reads at the new count.
  assign rd_addr   = ctrl.restart ? '0 : ctrl.count_next[IDX_W-1:0];
  assign use_table = ctrl.restart ||
                     (ctrl.count_next < {{(COUNT_W-USED_W){1'b0}}, used_n});

  // Growth past the table end: truncate the fraction, saturate at full scale.
  assign product = {{MULT_W{1'b0}}, value} * {{DUR_W{1'b0}}, ctrl.mult};
  assign shifted = product[PROD_W-1:FRAC_W];
  assign grown   = (|shifted[PROD_W-FRAC_W-1:DUR_W]) ? {DUR_W{1'b1}} : shifted[DUR_W-1:0];

  // Select and clamp; a zero limit means no cap.
  assign picked  = use_table ? tbl[rd_addr] : grown;
  assign clamped = ((ctrl.limit != '0) && (picked > ctrl.limit)) ? ctrl.limit : picked;

  // An empty table leaves the value alone on restart.
  assign update = ctrl.advance || (ctrl.restart && (used_n != '0));

  always_ff @(posedge clk) begin
    if (rst) begin
      value <= '0;
    end else if (update) begin
      value <= clamped;
    end
  end

endmodule

// ----- design/backoff_timeout_sequencer_core.sv -----
// Top level of the backoff timeout sequencer.
// Accepts one word per cycle while the result side takes words, and returns one result
// word for each. Each word is captured in an input register; when it commits, each
// channel reads its table or multiplies its current value by the growth factor,
// clamps to its limit and stores the outcome, and that stored state is the result
// payload. Throughput is set by the update loop on the current values and the
// attempt count, so back-to-back words run at full rate unless the result side stalls. The
// duration tables are not cleared at reset; reading an entry that was never loaded
// returns an undefined duration. Configuration must be written only while idle.
`timescale 1ns / 1ps

module backoff_timeout_sequencer_core (
  input  logic                           clk,
  input  logic                           rst,
  bts_in_if.sink                         item,
  bts_out_if.source                      result,
  input  logic                           cfg_we,
  input  logic [bts_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bts_pkg::CFG_DATA_W-1:0] cfg_data
);
  import bts_pkg::*;

  // Configuration registers.
  logic [MULT_W-1:0] attempt_mult;
  logic [MULT_W-1:0] retry_mult;
  logic [DUR_W-1:0]  attempt_limit;
  logic [DUR_W-1:0]  retry_limit;
  logic [USED_W-1:0] attempt_used;
  logic [USED_W-1:0] retry_used;

  // Input register.
  logic             q_valid;
  op_t              q_op;
  logic [IDX_W-1:0] q_index;
  logic [DUR_W-1:0] q_value;

  logic               out_valid;
  logic [COUNT_W-1:0] count;
  logic [COUNT_W-1:0] count_next;
  logic               move;
  chan_ctrl_t         attempt_ctrl;
  chan_ctrl_t         retry_ctrl;

  always_ff @(posedge clk) begin
    if (rst) begin
      attempt_mult  <= MULT_W'(256);
      retry_mult    <= MULT_W'(256);
      attempt_limit <= '0;
      retry_limit   <= '0;
      attempt_used  <= '0;
      retry_used    <= '0;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_ATTEMPT_MULT:  attempt_mult  <= cfg_data[MULT_W-1:0];
        CFG_RETRY_MULT:    retry_mult    <= cfg_data[MULT_W-1:0];
        CFG_ATTEMPT_LIMIT: attempt_limit <= cfg_data[DUR_W-1:0];
        CFG_RETRY_LIMIT:   retry_limit   <= cfg_data[DUR_W-1:0];
        CFG_ATTEMPT_USED:  attempt_used  <= cfg_data[USED_W-1:0];
        CFG_RETRY_USED:    retry_used    <= cfg_data[USED_W-1:0];
        default: ;
      endcase
    end
  end

  // The held word commits when the result stage is free or being emptied.
  assign move       = q_valid && (!out_valid || result.ready);
  assign item.ready = !q_valid || move;

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (item.ready) begin
      q_valid <= item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      q_op    <= op_t'(item.op);
      q_index <= item.entry_index;
      q_value <= item.duration_value;
    end
  end

  // Attempt count after the held word, saturating at full scale.
  always_comb begin
    case (q_op)
      OP_RESTART: count_next = '0;
      OP_NEXT:    count_next = (count == {COUNT_W{1'b1}}) ? count : count + COUNT_W'(1);
      default:    count_next = count;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (move) begin
      count <= count_next;
    end
  end

  // Channel controls, active only on the commit cycle.
  always_comb begin
    attempt_ctrl.restart    = move && (q_op == OP_RESTART);
    attempt_ctrl.advance    = move && (q_op == OP_NEXT);
    attempt_ctrl.load       = move && (q_op == OP_LOAD_ATTEMPT);
    attempt_ctrl.load_index = q_index;
    attempt_ctrl.load_value = q_value;
    attempt_ctrl.count_next = count_next;
    attempt_ctrl.mult       = attempt_mult;
    attempt_ctrl.limit      = attempt_limit;
    attempt_ctrl.used       = attempt_used;

    retry_ctrl.restart      = move && (q_op == OP_RESTART);
    retry_ctrl.advance      = move && (q_op == OP_NEXT);
    retry_ctrl.load         = move && (q_op == OP_LOAD_RETRY);
    retry_ctrl.load_index   = q_index;
    retry_ctrl.load_value   = q_value;
    retry_ctrl.count_next   = count_next;
    retry_ctrl.mult         = retry_mult;
    retry_ctrl.limit        = retry_limit;
    retry_ctrl.used         = retry_used;
  end

  bts_channel u_attempt (
    .clk   (clk),
    .rst   (rst),
    .ctrl  (attempt_ctrl),
    .value (result.attempt_timeout)
  );

  bts_channel u_retry (
    .clk   (clk),
    .rst   (rst),
    .ctrl  (retry_ctrl),
    .value (result.retry_delay)
  );

  // Result valid; the payload is the state, which changes only on commit.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (move) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  assign result.valid         = out_valid;
  assign result.attempt_count = count;

endmodule

// ----- design/bts_checker.sv -----
// Port-level checks for the backoff timeout sequencer, bound to the top level.
`timescale 1ns / 1ps

module bts_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        item_valid,
  input logic                        item_ready,
  input logic                        result_valid,
  input logic                        result_ready,
  input logic [bts_pkg::DUR_W-1:0]   attempt_timeout,
  input logic [bts_pkg::DUR_W-1:0]   retry_delay,
  input logic [bts_pkg::COUNT_W-1:0] attempt_count
);
  import bts_pkg::*;

  // A stalled result word holds still.
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=>
      result_valid && $stable(attempt_timeout) && $stable(retry_delay) &&
      $stable(attempt_count))
    else $error("result word changed while stalled");

  // With the result stage empty the input side never stalls.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !result_valid |-> item_ready)
    else $error("input stalled with empty result stage");

  // A result appears from idle only after an accepted input word has passed the input register.
  a_result_from_input: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(item_valid && item_ready, 2))
    else $error("result word without a matching input word");

endmodule

bind backoff_timeout_sequencer_core bts_checker u_bts_checker (
  .clk             (clk),
  .rst             (rst),
  .item_valid      (item.valid),
  .item_ready      (item.ready),
  .result_valid    (result.valid),
  .result_ready    (result.ready),
  .attempt_timeout (result.attempt_timeout),
  .retry_delay     (result.retry_delay),
  .attempt_count   (result.attempt_count)
);

// ----- verif/bts_checker.sv -----
// Scoreboard for the backoff timeout sequencer: predicts each result word and compares it.
`timescale 1ns / 1ps

module bts_scoreboard (
  input  logic                           clk,
  input  logic                           rst,
  bts_in_if                              item,
  bts_out_if                             result,
  input  logic                           cfg_we,
  input  logic [bts_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bts_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                             fail_count,
  output int                             outstanding
);
  import bts_pkg::*;

  // Only the first mismatches are printed; all of them are counted.
  localparam int REPORT_CAP = 40;

  typedef struct {
    logic [DUR_W-1:0]   attempt_timeout;
    logic [DUR_W-1:0]   retry_delay;
    logic [COUNT_W-1:0] attempt_count;
  } backoff_state_t;

  // Shadow copy of the block's tables, channel values and settings.
  logic [DUR_W-1:0]   attempt_tab [TABLE_DEPTH];
  logic [DUR_W-1:0]   retry_tab   [TABLE_DEPTH];
  logic [DUR_W-1:0]   cur_timeout;
  logic [DUR_W-1:0]   cur_delay;
  logic [COUNT_W-1:0] cur_count;
  logic [MULT_W-1:0]  attempt_mult;
  logic [MULT_W-1:0]  retry_mult;
  logic [DUR_W-1:0]   attempt_cap;
  logic [DUR_W-1:0]   retry_cap;
  logic [USED_W-1:0]  attempt_used;
  logic [USED_W-1:0]  retry_used;

  backoff_state_t predicted_backoffs[$];
  int             report_count;

  initial begin
    fail_count   = 0;
    outstanding  = 0;
    report_count = 0;
  end

  // Entries in use, with counts past the table depth taken as the full depth.
  function automatic int entries_in_use(logic [USED_W-1:0] used);
    return (int'(used) > TABLE_DEPTH) ? TABLE_DEPTH : int'(used);
  endfunction

  // A nonzero limit caps the duration.
  function automatic logic [DUR_W-1:0] cap_duration(logic [DUR_W-1:0] v, logic [DUR_W-1:0] lim);
    return (lim != '0 && v > lim) ? lim : v;
  endfunction

  // Fixed-point growth: truncate the fraction bits, saturate at the duration maximum.
  function automatic logic [DUR_W-1:0] grow_duration(logic [DUR_W-1:0] v, logic [MULT_W-1:0] m);
    logic [PROD_W-1:0] prod;
    logic [PROD_W-1:0] whole;
    prod  = PROD_W'(v) * PROD_W'(m);
    whole = prod >> FRAC_W;
    return (whole > PROD_W'({DUR_W{1'b1}})) ? {DUR_W{1'b1}} : whole[DUR_W-1:0];
  endfunction

  // Next value of one channel after the count has moved on.
  function automatic logic [DUR_W-1:0] step_channel(logic [DUR_W-1:0] cur, logic [DUR_W-1:0] entry,
                                                    logic [USED_W-1:0] used, logic [MULT_W-1:0] m,
                                                    logic [DUR_W-1:0] lim, logic [COUNT_W-1:0] cnt);
    logic [DUR_W-1:0] v;
    if (int'(cnt) < entries_in_use(used)) begin
      v = entry;
    end else begin
      v = grow_duration(cur, m);
    end
    return cap_duration(v, lim);
  endfunction

  // Apply one accepted input word and queue the state it leaves.
  task automatic advance_backoff(logic [1:0] op, logic [IDX_W-1:0] idx, logic [DUR_W-1:0] dur);
    backoff_state_t exp;
    case (op)
      OP_RESTART: begin
        cur_count = '0;
        if (entries_in_use(attempt_used) > 0) cur_timeout = cap_duration(attempt_tab[0], attempt_cap);
        if (entries_in_use(retry_used) > 0) cur_delay = cap_duration(retry_tab[0], retry_cap);
      end
      OP_NEXT: begin
        if (cur_count != {COUNT_W{1'b1}}) cur_count = cur_count + 1'b1;
        cur_timeout = step_channel(cur_timeout, attempt_tab[cur_count[IDX_W-1:0]], attempt_used,
                                   attempt_mult, attempt_cap, cur_count);
        cur_delay   = step_channel(cur_delay, retry_tab[cur_count[IDX_W-1:0]], retry_used,
                                   retry_mult, retry_cap, cur_count);
      end
      OP_LOAD_ATTEMPT: attempt_tab[idx] = dur;
      default:         retry_tab[idx] = dur;
    endcase
    exp.attempt_timeout = cur_timeout;
    exp.retry_delay     = cur_delay;
    exp.attempt_count   = cur_count;
    predicted_backoffs.insert(predicted_backoffs.size(), exp);
  endtask

  task automatic check_field(string field, logic [DUR_W-1:0] exp, logic [DUR_W-1:0] act,
                             ref bit bad);
    if (exp !== act) begin
      bad = 1'b1;
      if (report_count < REPORT_CAP) begin
        $error("%s: expected %0h, got %0h", field, exp, act);
        report_count++;
      end
    end
  endtask

  // Sampling happens at the rising edge; the stimulus changes only at the falling edge.
  always @(posedge clk) begin
    backoff_state_t exp;
    bit             bad;
    if (rst) begin
      cur_timeout  = '0;
      cur_delay    = '0;
      cur_count    = '0;
      attempt_mult = MULT_W'(256);
      retry_mult   = MULT_W'(256);
      attempt_cap  = '0;
      retry_cap    = '0;
      attempt_used = '0;
      retry_used   = '0;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        attempt_tab[i] = '0;
        retry_tab[i]   = '0;
      end
      predicted_backoffs.delete();
    end else begin
      // Register writes.
      if (cfg_we) begin
        case (cfg_index)
          CFG_ATTEMPT_MULT:  attempt_mult = cfg_data[MULT_W-1:0];
          CFG_RETRY_MULT:    retry_mult   = cfg_data[MULT_W-1:0];
          CFG_ATTEMPT_LIMIT: attempt_cap  = cfg_data[DUR_W-1:0];
          CFG_RETRY_LIMIT:   retry_cap    = cfg_data[DUR_W-1:0];
          CFG_ATTEMPT_USED:  attempt_used = cfg_data[USED_W-1:0];
          CFG_RETRY_USED:    retry_used   = cfg_data[USED_W-1:0];
          default: ;
        endcase
      end

      // Result words against the oldest prediction.
      if (result.valid && result.ready) begin
        if (predicted_backoffs.size() == 0) begin
          fail_count++;
          if (report_count < REPORT_CAP) begin
            $error("result word with no prediction waiting");
            report_count++;
          end
        end else begin
          exp = predicted_backoffs.pop_front();
          bad = 1'b0;
          check_field("attempt_timeout", exp.attempt_timeout, result.attempt_timeout, bad);
          check_field("retry_delay", exp.retry_delay, result.retry_delay, bad);
          check_field("attempt_count", DUR_W'(exp.attempt_count), DUR_W'(result.attempt_count),
                      bad);
          if (bad) fail_count++;
        end
      end

      // Input words feed the predictor.
      if (item.valid && item.ready) begin
        advance_backoff(item.op, item.entry_index, item.duration_value);
      end
    end
    outstanding = predicted_backoffs.size();
  end

endmodule

// ----- verif/tb.sv -----
// Top of the backoff timeout sequencer testbench: stimulus, reset, watchdog and verdict.
`timescale 1ns / 1ps

module tb;
  import bts_pkg::*;

  localparam int                   IDLE_LIMIT    = 4000;
  localparam int                   RANDOM_PHASES = 12;
  localparam int                   PHASE_WORDS   = 110;
  localparam int                   LONG_NEXTS    = 40;
  localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED  = 3'd7;
  localparam logic [DUR_W-1:0]     DUR_ALL_ONES  = {DUR_W{1'b1}};

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    fail_count;
  int                    outstanding;

  // Sender and receiver idling controls, set per phase.
  bit tx_gaps;
  int burst_left;
  int rx_mode;
  bit rx_state;
  int rx_left;
  int idle_cycles_seen;

  bts_in_if  item_ch ();
  bts_out_if result_ch ();

  backoff_timeout_sequencer_core DUT (
    .clk       (clk),
    .rst       (rst),
    .item      (item_ch),
    .result    (result_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  bts_scoreboard scoreboard (
    .clk         (clk),
    .rst         (rst),
    .item        (item_ch),
    .result      (result_ch),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Receiver: always ready, alternating ready and stall runs, or a random stall pattern.
  initial begin
    result_ch.ready = 1'b0;
    rx_state        = 1'b1;
    rx_left         = 0;
    forever begin
      @(negedge clk);
      case (rx_mode)
        0: result_ch.ready <= 1'b1;
        1: begin
          if (rx_left == 0) begin
            rx_state = ~rx_state;
            rx_left  = rx_state ? $urandom_range(1, 20) : $urandom_range(1, 12);
          end
          rx_left--;
          result_ch.ready <= rx_state;
        end
        default: result_ch.ready <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  // Watchdog: too many cycles with no word moving on either channel ends the run.
  always @(posedge clk) begin
    if (rst || (item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready)) begin
      idle_cycles_seen <= 0;
    end else if (idle_cycles_seen >= IDLE_LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end else begin
      idle_cycles_seen <= idle_cycles_seen + 1;
    end
  end

  task automatic idle_cycles(int n);
    repeat (n) begin
      @(negedge clk);
      item_ch.valid <= 1'b0;
    end
  endtask

  // Offer one word and hold it until it is taken; valid stays high until the next falling edge.
  task automatic push_word(op_t op, logic [IDX_W-1:0] idx, logic [DUR_W-1:0] dur);
    if (tx_gaps) begin
      if (burst_left == 0) begin
        idle_cycles($urandom_range(1, 15));
        burst_left = $urandom_range(1, 24);
      end
      burst_left--;
    end
    @(negedge clk);
    item_ch.valid          <= 1'b1;
    item_ch.op             <= op;
    item_ch.entry_index    <= idx;
    item_ch.duration_value <= dur;
    do @(posedge clk); while (!item_ch.ready);
  endtask

  // Wait until every predicted word has come back, then let the pipeline settle.
  task automatic drain();
    @(negedge clk);
    item_ch.valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic set_config(logic [MULT_W-1:0] amult, logic [MULT_W-1:0] rmult,
                            logic [DUR_W-1:0] alim, logic [DUR_W-1:0] rlim,
                            logic [USED_W-1:0] aused, logic [USED_W-1:0] rused);
    write_reg(CFG_ATTEMPT_MULT, CFG_DATA_W'(amult));
    write_reg(CFG_RETRY_MULT, CFG_DATA_W'(rmult));
    write_reg(CFG_ATTEMPT_LIMIT, alim);
    write_reg(CFG_RETRY_LIMIT, rlim);
    write_reg(CFG_ATTEMPT_USED, CFG_DATA_W'(aused));
    write_reg(CFG_RETRY_USED, CFG_DATA_W'(rused));
  endtask

  function automatic logic [MULT_W-1:0] pick_mult();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return {MULT_W{1'b1}};
      2: return MULT_W'(256);
      3: return MULT_W'(257);
      4: return MULT_W'(384);
      5: return MULT_W'(512);
      6: return MULT_W'($urandom_range(0, 1023));
      default: return MULT_W'($urandom);
    endcase
  endfunction

  function automatic logic [DUR_W-1:0] pick_limit();
    case ($urandom_range(0, 5))
      0, 1: return '0;
      2: return DUR_ALL_ONES;
      3: return DUR_W'($urandom_range(1, 5000));
      default: return DUR_W'($urandom);
    endcase
  endfunction

  function automatic logic [USED_W-1:0] pick_used();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return USED_W'($urandom_range(17, 31));
      2: return USED_W'(TABLE_DEPTH);
      default: return USED_W'($urandom_range(1, 15));
    endcase
  endfunction

  function automatic logic [DUR_W-1:0] pick_duration();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return DUR_ALL_ONES;
      2, 3, 4: return DUR_W'($urandom_range(1, 5000));
      5: return DUR_W'({1'b1, DUR_W'($urandom_range(0, 65535))} >> 1);
      default: return DUR_W'($urandom);
    endcase
  endfunction

  function automatic op_t pick_op();
    return op_t'($urandom_range(0, 3));
  endfunction

  // Random words: mostly a restart and a run of next words, some loads, some noise.
  task automatic random_words(int target);
    int sent;
    int run;
    sent = 0;
    while (sent < target) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5, 6: begin
          push_word(OP_RESTART, IDX_W'($urandom_range(0, 15)), DUR_W'($urandom));
          run  = $urandom_range(1, 24);
          sent = sent + 1 + run;
          repeat (run) begin
            if ($urandom_range(0, 9) == 0) begin
              push_word(($urandom_range(0, 1) != 0) ? OP_LOAD_ATTEMPT : OP_LOAD_RETRY,
                        IDX_W'($urandom_range(0, 15)), pick_duration());
            end else begin
              push_word(OP_NEXT, IDX_W'($urandom_range(0, 15)), DUR_W'($urandom));
            end
          end
        end
        7, 8: begin
          run  = $urandom_range(1, 4);
          sent = sent + run;
          repeat (run) begin
            push_word(($urandom_range(0, 1) != 0) ? OP_LOAD_ATTEMPT : OP_LOAD_RETRY,
                      IDX_W'($urandom_range(0, 15)), pick_duration());
          end
        end
        default: begin
          run  = $urandom_range(1, 6);
          sent = sent + run;
          repeat (run) push_word(pick_op(), IDX_W'($urandom_range(0, 15)), DUR_W'($urandom));
        end
      endcase
    end
  endtask

  initial begin
    rst                    = 1'b1;
    cfg_we                 = 1'b0;
    cfg_index              = CFG_ATTEMPT_MULT;
    cfg_data               = '0;
    item_ch.valid          = 1'b0;
    item_ch.op             = OP_RESTART;
    item_ch.entry_index    = '0;
    item_ch.duration_value = '0;
    idle_cycles_seen       = 0;
    tx_gaps                = 1'b0;
    burst_left             = 0;
    rx_mode                = 0;

    repeat (10) @(negedge clk);
    rst <= 1'b0;

    // Fill both tables completely while no entries are in use, so no read ever hits
    // an entry that was never loaded.
    tx_gaps = 1'b1;
    rx_mode = 1;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      push_word(OP_LOAD_ATTEMPT, i[IDX_W-1:0],
                (i == 7) ? DUR_ALL_ONES : (i == 9) ? '0 : DUR_W'($urandom_range(1, 5000)));
    end
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      push_word(OP_LOAD_RETRY, i[IDX_W-1:0], pick_duration());
    end
    drain();

    // Doubling attempt channel with an empty retry table on restart.
    set_config(MULT_W'(512), MULT_W'(384), '0, '0, USED_W'(4), '0);
    push_word(OP_RESTART, '1, DUR_ALL_ONES);
    repeat (5) push_word(OP_NEXT, IDX_W'($urandom_range(0, 15)), DUR_W'($urandom));
    push_word(OP_LOAD_ATTEMPT, '1, DUR_ALL_ONES);
    push_word(OP_LOAD_RETRY, '0, DUR_ALL_ONES);
    drain();

    // Largest and zero multipliers, both limits active, entry counts at and past the depth.
    write_reg(CFG_UNMAPPED, '1);
    set_config('1, '0, DUR_W'(1000), DUR_W'(50), '1, USED_W'(TABLE_DEPTH));
    push_word(OP_RESTART, '0, '0);
    repeat (4) push_word(OP_NEXT, '0, '0);
    push_word(OP_LOAD_ATTEMPT, '0, '0);
    push_word(OP_LOAD_RETRY, '1, '0);
    push_word(OP_RESTART, IDX_W'($urandom_range(0, 15)), DUR_W'($urandom));
    repeat (2) push_word(OP_NEXT, IDX_W'($urandom_range(0, 15)), DUR_W'($urandom));
    drain();

    // A long run of next words sent without gaps, well past both table ends.
    tx_gaps = 1'b0;
    rx_mode = 2;
    set_config(MULT_W'(256), MULT_W'(300), '0, DUR_ALL_ONES, USED_W'(20), USED_W'(2));
    push_word(OP_RESTART, '0, '0);
    repeat (LONG_NEXTS) push_word(OP_NEXT, IDX_W'($urandom_range(0, 15)), DUR_W'($urandom));
    drain();

    // Random phases, each with its own settings and idling.
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      tx_gaps    = (ph % 3 != 0);
      rx_mode    = (ph % 4 == 0) ? 0 : $urandom_range(1, 2);
      burst_left = 0;
      set_config(pick_mult(), pick_mult(), pick_limit(), pick_limit(), pick_used(), pick_used());
      random_words(PHASE_WORDS);
      drain();
    end

    repeat (10) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
